// ===== hdl/hkm_pkg.sv =====
// Shared types and constants for the HDLC keepalive link monitor.
package hkm_pkg;

  localparam int HDR_LEN       = 4;
  localparam int CFG_INDEX_W   = 3;
  localparam int IN_TDATA_W    = 136;
  localparam int OUT_TDATA_W   = 136;

  localparam logic [7:0]  ADDR_MCAST      = 8'h8F;
  localparam logic [7:0]  ADDR_UCAST      = 8'h0F;
  localparam logic [15:0] PROTO_KEEPALIVE = 16'h8035;
  localparam logic [15:0] PROTO_SYSINFO   = 16'h2000;
  localparam logic [15:0] PROTO_IPV4      = 16'h0800;
  localparam logic [15:0] PROTO_IPX       = 16'h8137;
  localparam logic [15:0] PROTO_IPV6      = 16'h86DD;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;
  localparam logic [31:0] MS_PER_SEC      = 32'd1000;

  localparam logic [31:0] KA_ADDR_REQUEST = 32'd0;
  localparam logic [31:0] KA_ADDR_REPLY   = 32'd1;
  localparam logic [31:0] KA_REQUEST      = 32'd2;

  localparam logic [2:0] VERDICT_DELIVER  = 3'd0;
  localparam logic [2:0] VERDICT_CONSUMED = 3'd1;
  localparam logic [2:0] VERDICT_DROP     = 3'd2;
  localparam logic [2:0] VERDICT_ERROR    = 3'd3;
  localparam logic [2:0] VERDICT_TICK     = 3'd4;

  localparam logic [1:0] SEND_ADDR_REPLY  = 2'd1;
  localparam logic [1:0] SEND_REQUEST     = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_MASK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_KNOWN = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_DELIVER,
    OP_CONSUME,
    OP_DROP,
    OP_ERROR,
    OP_ADDR_REQ,
    OP_KEEPALIVE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] ka_first;
    logic [31:0] ka_second;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        send_valid;
    logic [1:0]  send_type;
    logic [31:0] send_first;
    logic [31:0] send_second;
    logic [31:0] send_time_ms;
    logic        link_is_up;
    logic [31:0] error_total;
  } result_t;

endpackage

// ===== hdl/hkm_front.sv =====
// Front end: classifies each incoming tick or frame header into a command.
module hkm_front #(
  parameter int SHORT_BODY_LEN = 14,
  parameter int LONG_BODY_LEN  = 18
) (
  input  logic          kind,
  input  logic [11:0]   frame_length,
  input  logic [7:0]    address_byte,
  input  logic [15:0]   frame_protocol,
  input  logic [31:0]   ka_type,
  input  logic [31:0]   ka_first,
  input  logic [31:0]   ka_second,
  output hkm_pkg::cmd_t cmd
);
  import hkm_pkg::*;

  localparam logic [11:0] SHORT_FRAME = 12'(HDR_LEN + SHORT_BODY_LEN);
  localparam logic [11:0] LONG_FRAME  = 12'(HDR_LEN + LONG_BODY_LEN);
  localparam logic [11:0] MIN_FRAME   = 12'(HDR_LEN);

  logic bad_header;
  logic data_proto;
  logic bad_ka_length;

  assign bad_header = (frame_length < MIN_FRAME) ||
                      ((address_byte != ADDR_MCAST) && (address_byte != ADDR_UCAST));
  assign data_proto = (frame_protocol == PROTO_IPV4) || (frame_protocol == PROTO_IPX) ||
                      (frame_protocol == PROTO_IPV6);
  assign bad_ka_length = (frame_length != SHORT_FRAME) && (frame_length != LONG_FRAME);

  always_comb begin
    cmd.ka_first  = ka_first;
    cmd.ka_second = ka_second;
    priority if (!kind) begin
      cmd.op = OP_TICK;
    end else if (bad_header) begin
      cmd.op = OP_ERROR;
    end else if (data_proto) begin
      cmd.op = OP_DELIVER;
    end else if (frame_protocol == PROTO_SYSINFO) begin
      cmd.op = OP_CONSUME;
    end else if (frame_protocol != PROTO_KEEPALIVE) begin
      cmd.op = OP_DROP;
    end else if (bad_ka_length) begin
      cmd.op = OP_ERROR;
    end else if (ka_type == KA_ADDR_REQUEST) begin
      cmd.op = OP_ADDR_REQ;
    end else if (ka_type == KA_ADDR_REPLY) begin
      cmd.op = OP_ERROR;
    end else if (ka_type == KA_REQUEST) begin
      cmd.op = OP_KEEPALIVE;
    end else begin
      cmd.op = OP_DROP;
    end
  end

endmodule

// ===== hdl/hkm_queue.sv =====
// Two-entry command queue between the front end and the back end.
module hkm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hkm_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output hkm_pkg::cmd_t head
);
  import hkm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/hkm_back.sv =====
// Back end: configuration registers, protocol state and the result register.
module hkm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hkm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           cmd_valid,
  input  hkm_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output hkm_pkg::result_t               res
);
  import hkm_pkg::*;

  logic [7:0]  poll_interval;
  logic [7:0]  link_timeout;
  logic [31:0] local_address;
  logic [31:0] local_mask;
  logic        address_known;

  logic        link_up,         link_up_next;
  logic        request_pending, request_pending_next;
  logic [31:0] tx_sequence,     tx_sequence_next;
  logic [31:0] rx_sequence,     rx_sequence_next;
  logic [15:0] reply_age,       reply_age_next;
  logic [7:0]  poll_countdown,  poll_countdown_next;
  logic [31:0] uptime_seconds,  uptime_seconds_next;
  logic [31:0] uptime_ms,       uptime_ms_next;
  logic [31:0] error_count,     error_count_next;
  result_t     res_next;
  logic        take;

  assign cfg_ready = 1'b1;
  assign take      = cmd_valid && (!res_valid || res_ready);
  assign cmd_pop   = take;

  always_comb begin
    link_up_next         = link_up;
    request_pending_next = request_pending;
    tx_sequence_next     = tx_sequence;
    rx_sequence_next     = rx_sequence;
    reply_age_next       = reply_age;
    poll_countdown_next  = poll_countdown;
    uptime_seconds_next  = uptime_seconds;
    uptime_ms_next       = uptime_ms;
    error_count_next     = error_count;
    res_next             = '0;
    unique case (cmd.op)
      OP_TICK: begin
        res_next.verdict    = VERDICT_TICK;
        uptime_seconds_next = uptime_seconds + 32'd1;
        uptime_ms_next      = uptime_ms + MS_PER_SEC;
        if (reply_age != AGE_MAX) begin
          reply_age_next = reply_age + 16'd1;
        end
        if (poll_countdown <= 8'd1) begin
          if (link_up && (reply_age_next > {8'd0, link_timeout})) begin
            link_up_next = 1'b0;
          end
          tx_sequence_next      = tx_sequence + 32'd1;
          res_next.send_valid   = 1'b1;
          res_next.send_type    = SEND_REQUEST;
          res_next.send_first   = tx_sequence_next;
          res_next.send_second  = rx_sequence;
          res_next.send_time_ms = uptime_ms_next;
          request_pending_next  = 1'b1;
          poll_countdown_next   = poll_interval;
        end else begin
          poll_countdown_next = poll_countdown - 8'd1;
        end
      end
      OP_DELIVER: res_next.verdict = VERDICT_DELIVER;
      OP_CONSUME: res_next.verdict = VERDICT_CONSUMED;
      OP_DROP:    res_next.verdict = VERDICT_DROP;
      OP_ERROR: begin
        res_next.verdict = VERDICT_ERROR;
        error_count_next = error_count + 32'd1;
      end
      OP_ADDR_REQ: begin
        res_next.verdict = VERDICT_CONSUMED;
        if (address_known) begin
          res_next.send_valid   = 1'b1;
          res_next.send_type    = SEND_ADDR_REPLY;
          res_next.send_first   = local_address;
          res_next.send_second  = local_mask;
          res_next.send_time_ms = uptime_ms;
        end
      end
      OP_KEEPALIVE: begin
        res_next.verdict = VERDICT_CONSUMED;
        rx_sequence_next = cmd.ka_first;
        if (request_pending && (cmd.ka_second == tx_sequence)) begin
          reply_age_next = 16'd0;
          link_up_next   = 1'b1;
        end
      end
      default: res_next.verdict = VERDICT_DROP;
    endcase
    res_next.link_is_up  = link_up_next;
    res_next.error_total = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
    if (rst) begin
      poll_interval   <= 8'd10;
      link_timeout    <= 8'd25;
      local_address   <= 32'd0;
      local_mask      <= 32'hFFFF_FFFF;
      address_known   <= 1'b0;
      link_up         <= 1'b0;
      request_pending <= 1'b0;
      tx_sequence     <= 32'd0;
      rx_sequence     <= 32'd0;
      reply_age       <= 16'd0;
      poll_countdown  <= 8'd1;
      uptime_seconds  <= 32'd0;
      uptime_ms       <= 32'd0;
      error_count     <= 32'd0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_POLL_INTERVAL: poll_interval <= cfg_data[7:0];
          REG_LINK_TIMEOUT:  link_timeout  <= cfg_data[7:0];
          REG_LOCAL_ADDRESS: local_address <= cfg_data;
          REG_LOCAL_MASK:    local_mask    <= cfg_data;
          REG_ADDRESS_KNOWN: address_known <= cfg_data[0];
          default: ;
        endcase
      end
      if (take) begin
        link_up         <= link_up_next;
        request_pending <= request_pending_next;
        tx_sequence     <= tx_sequence_next;
        rx_sequence     <= rx_sequence_next;
        reply_age       <= reply_age_next;
        poll_countdown  <= poll_countdown_next;
        uptime_seconds  <= uptime_seconds_next;
        uptime_ms       <= uptime_ms_next;
        error_count     <= error_count_next;
        res_valid       <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/hdlc_keepalive_link_monitor.sv =====
// Top level of the HDLC keepalive link monitor.
//
// The slave stream carries one-second ticks and decoded received frame
// headers; each request yields exactly one result on the master stream,
// giving the frame's verdict, any keepalive or address reply to transmit,
// the link state and the running receive error count.
// The configuration channel writes the poll interval, link timeout, local
// address, mask and address-known flag; it is always ready.
// A request is classified at the input, passes a two-entry queue and is
// executed by the state update, whose result register feeds the master
// stream. An accepted request is registered in a queue entry and then in
// the result register, and one request per cycle is sustained while the
// receiver is ready.
// When the receiver stalls, the result is held, the queue fills and the
// slave side stops taking requests once both entries are occupied.
// Reset empties the queue, restores the register defaults and starts the
// protocol afresh with the first keepalive request after one tick.
module hdlc_keepalive_link_monitor #(
  parameter int SHORT_BODY_LEN = 14,
  parameter int LONG_BODY_LEN  = 18
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // frame_length, address_byte, frame_protocol, ka_type, ka_first, ka_second
  input  logic [hkm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // send_valid, send_type, send_first, send_second, send_time_ms,
  // link_is_up, error_total
  output logic [hkm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // verdict
  output logic [2:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hkm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);
  import hkm_pkg::*;

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    q_not_full;
  logic    q_not_empty;
  logic    q_pop;
  result_t res;

  assign s_axis_tready = q_not_full;

  hkm_front #(
    .SHORT_BODY_LEN (SHORT_BODY_LEN),
    .LONG_BODY_LEN  (LONG_BODY_LEN)
  ) u_front (
    .kind           (s_axis_tuser),
    .frame_length   (s_axis_tdata[11:0]),
    .address_byte   (s_axis_tdata[19:12]),
    .frame_protocol (s_axis_tdata[35:20]),
    .ka_type        (s_axis_tdata[67:36]),
    .ka_first       (s_axis_tdata[99:68]),
    .ka_second      (s_axis_tdata[131:100]),
    .cmd            (front_cmd)
  );

  hkm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  hkm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tuser = res.verdict;
  assign m_axis_tdata = {4'd0, res.error_total, res.link_is_up, res.send_time_ms,
                         res.send_second, res.send_first, res.send_type, res.send_valid};

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> q_not_empty)
    else $error("accepted request did not reach the queue");

  a_send_only_on_tick_or_consume: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      ((m_axis_tuser == VERDICT_TICK) || (m_axis_tuser == VERDICT_CONSUMED)))
    else $error("transmit flagged on a result that cannot send");

  a_send_type_matches: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[2:1] == SEND_REQUEST)) |->
      (m_axis_tuser == VERDICT_TICK))
    else $error("keepalive request sent outside a tick");

endmodule

// ===== test/tb_hdlc_keepalive_link_monitor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HDLC keepalive link monitor, predicting every result in step.
module tb_hdlc_keepalive_link_monitor;
  import hkm_pkg::*;

  localparam int SHORT_BODY = 14;
  localparam int LONG_BODY = 18;
  localparam logic [11:0] KA_SHORT_LEN = 12'(HDR_LEN + SHORT_BODY);
  localparam logic [11:0] KA_LONG_LEN = 12'(HDR_LEN + LONG_BODY);
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_FRAME = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic        kind;
    logic [11:0] len;
    logic [7:0]  addr;
    logic [15:0] proto;
    logic [31:0] ktype;
    logic [31:0] kfirst;
    logic [31:0] ksecond;
  } hdr_item_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic [2:0]               m_axis_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [31:0]              cfg_data = '0;

  hdlc_keepalive_link_monitor #(
    .SHORT_BODY_LEN(SHORT_BODY),
    .LONG_BODY_LEN(LONG_BODY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted register and protocol state.
  logic [7:0]  poll_interval_m = 8'd10;
  logic [7:0]  link_timeout_m = 8'd25;
  logic [31:0] own_address_m = 32'd0;
  logic [31:0] own_mask_m = 32'hFFFF_FFFF;
  logic        address_known_m = 1'b0;
  logic        link_up_m = 1'b0;
  logic        reply_pending_m = 1'b0;
  logic [31:0] tx_seq_m = 32'd0;
  logic [31:0] rx_seq_m = 32'd0;
  logic [15:0] reply_age_m = 16'd0;
  logic [7:0]  countdown_m = 8'd1;
  logic [31:0] uptime_m = 32'd0;
  logic [31:0] errors_m = 32'd0;

  result_t expected_results[$];
  int      failures = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;
  int      hold_off_seq = 0;
  int      hold_off_seen = 0;
  int      sink_wait = 0;

  function automatic result_t monitor_step(hdr_item_t it);
    result_t r;
    logic    bad;
    r = '0;
    bad = 1'b0;
    if (it.kind == KIND_TICK) begin
      r.verdict = VERDICT_TICK;
      uptime_m = uptime_m + 32'd1;
      if (reply_age_m != AGE_MAX) reply_age_m = reply_age_m + 16'd1;
      if (countdown_m <= 8'd1) begin
        if (link_up_m && reply_age_m > {8'd0, link_timeout_m}) link_up_m = 1'b0;
        tx_seq_m = tx_seq_m + 32'd1;
        r.send_valid = 1'b1;
        r.send_type = SEND_REQUEST;
        r.send_first = tx_seq_m;
        r.send_second = rx_seq_m;
        r.send_time_ms = uptime_m * MS_PER_SEC;
        reply_pending_m = 1'b1;
        countdown_m = poll_interval_m;
      end else begin
        countdown_m = countdown_m - 8'd1;
      end
    end else if (it.len < HDR_LEN || (it.addr != ADDR_MCAST && it.addr != ADDR_UCAST)) begin
      bad = 1'b1;
    end else if (it.proto == PROTO_IPV4 || it.proto == PROTO_IPX || it.proto == PROTO_IPV6) begin
      r.verdict = VERDICT_DELIVER;
    end else if (it.proto == PROTO_SYSINFO) begin
      r.verdict = VERDICT_CONSUMED;
    end else if (it.proto != PROTO_KEEPALIVE) begin
      r.verdict = VERDICT_DROP;
    end else if (it.len != KA_SHORT_LEN && it.len != KA_LONG_LEN) begin
      bad = 1'b1;
    end else begin
      case (it.ktype)
        KA_ADDR_REQUEST: begin
          r.verdict = VERDICT_CONSUMED;
          if (address_known_m) begin
            r.send_valid = 1'b1;
            r.send_type = SEND_ADDR_REPLY;
            r.send_first = own_address_m;
            r.send_second = own_mask_m;
            r.send_time_ms = uptime_m * MS_PER_SEC;
          end
        end
        KA_ADDR_REPLY: bad = 1'b1;
        KA_REQUEST: begin
          r.verdict = VERDICT_CONSUMED;
          rx_seq_m = it.kfirst;
          if (reply_pending_m && it.ksecond == tx_seq_m) begin
            reply_age_m = 16'd0;
            link_up_m = 1'b1;
          end
        end
        default: r.verdict = VERDICT_DROP;
      endcase
    end
    if (bad) begin
      errors_m = errors_m + 32'd1;
      r.verdict = VERDICT_ERROR;
    end
    r.link_is_up = link_up_m;
    r.error_total = errors_m;
    return r;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("verdict %0d send %0b type %0d first %h second %h ms %h up %0b errors %h",
                     r.verdict, r.send_valid, r.send_type, r.send_first, r.send_second,
                     r.send_time_ms, r.link_is_up, r.error_total);
  endfunction

  function automatic hdr_item_t mk_frame(logic [11:0] len, logic [7:0] addr, logic [15:0] proto,
                                         logic [31:0] ktype, logic [31:0] kfirst,
                                         logic [31:0] ksecond);
    hdr_item_t it;
    it.kind = KIND_FRAME;
    it.len = len;
    it.addr = addr;
    it.proto = proto;
    it.ktype = ktype;
    it.kfirst = kfirst;
    it.ksecond = ksecond;
    return it;
  endfunction

  function automatic hdr_item_t mk_tick();
    hdr_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic logic [7:0] good_addr();
    return $urandom_range(0, 1) ? ADDR_MCAST : ADDR_UCAST;
  endfunction

  function automatic logic [11:0] ka_len();
    return $urandom_range(0, 1) ? KA_LONG_LEN : KA_SHORT_LEN;
  endfunction

  // Mostly well-formed items (keepalive exchanges, ticks and data frames), with raw noise mixed in.
  function automatic hdr_item_t random_item();
    hdr_item_t it;
    int        pick;
    int        echo;
    it.kind = KIND_FRAME;
    it.len = 12'($urandom);
    it.addr = 8'($urandom);
    it.proto = 16'($urandom);
    it.ktype = $urandom;
    it.kfirst = $urandom;
    it.ksecond = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.kind = KIND_TICK;
    end else if (pick < 58) begin
      it.len = ka_len();
      it.addr = good_addr();
      it.proto = PROTO_KEEPALIVE;
      it.ktype = KA_REQUEST;
      echo = $urandom_range(0, 99);
      if (echo < 65) it.ksecond = tx_seq_m;
      else if (echo < 80) it.ksecond = tx_seq_m - 32'd1;
    end else if (pick < 66) begin
      it.len = ka_len();
      it.addr = good_addr();
      it.proto = PROTO_KEEPALIVE;
      it.ktype = $urandom_range(0, 1) ? KA_ADDR_REQUEST : KA_ADDR_REPLY;
    end else if (pick < 80) begin
      it.len = 12'($urandom_range(HDR_LEN, 4095));
      it.addr = good_addr();
      case ($urandom_range(0, 3))
        0: it.proto = PROTO_IPV4;
        1: it.proto = PROTO_IPX;
        2: it.proto = PROTO_IPV6;
        default: it.proto = PROTO_SYSINFO;
      endcase
    end else if (pick < 88) begin
      it.addr = good_addr();
      it.proto = PROTO_KEEPALIVE;
      if ($urandom_range(0, 1)) it.len = ka_len();
    end else if ($urandom_range(0, 1)) begin
      it.addr = good_addr();
    end
    return it;
  endfunction

  task automatic send_header(input hdr_item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.ksecond, it.kfirst, it.ktype, it.proto, it.addr, it.len};
    s_axis_tuser <= it.kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(monitor_step(it));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_header(random_item());
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_POLL_INTERVAL: poll_interval_m = value[7:0];
      REG_LINK_TIMEOUT:  link_timeout_m = value[7:0];
      REG_LOCAL_ADDRESS: own_address_m = value;
      REG_LOCAL_MASK:    own_mask_m = value;
      REG_ADDRESS_KNOWN: address_known_m = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] poll, input logic [7:0] timeout,
                           input logic [31:0] addr, input logic [31:0] mask, input logic known);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_write(REG_POLL_INTERVAL, {24'd0, poll});
    cfg_write(REG_LINK_TIMEOUT, {24'd0, timeout});
    cfg_write(REG_LOCAL_ADDRESS, addr);
    cfg_write(REG_LOCAL_MASK, mask);
    cfg_write(REG_ADDRESS_KNOWN, {31'd0, known});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // A keepalive echo before any request has gone out must not raise the link.
    send_header(mk_frame(KA_LONG_LEN, ADDR_UCAST, PROTO_KEEPALIVE, KA_REQUEST, 32'd5, 32'd0));
    send_header(mk_tick());
    send_header(mk_frame(12'd0, ADDR_UCAST, PROTO_IPV4, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd3, ADDR_MCAST, PROTO_IPV4, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd4, 8'h00, PROTO_IPV4, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'hFFF, 8'hFF, PROTO_IPV4, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd4, ADDR_UCAST, PROTO_IPV4, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd100, ADDR_MCAST, PROTO_IPX, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'hFFF, ADDR_UCAST, PROTO_IPV6, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd20, ADDR_MCAST, PROTO_SYSINFO, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd40, ADDR_UCAST, 16'hFFFF, 32'd0, 32'd0, 32'd0));
    send_header(mk_frame(12'd21, ADDR_UCAST, PROTO_KEEPALIVE, KA_REQUEST, 32'd0, 32'd1));
    send_header(mk_frame(12'hFFF, ADDR_MCAST, PROTO_KEEPALIVE, KA_REQUEST, 32'd0, 32'd1));
    send_header(mk_frame(KA_SHORT_LEN, ADDR_UCAST, PROTO_KEEPALIVE, KA_ADDR_REQUEST,
                         32'd0, 32'd0));
    send_header(mk_frame(KA_LONG_LEN, ADDR_MCAST, PROTO_KEEPALIVE, KA_ADDR_REPLY,
                         32'd0, 32'd0));
    send_header(mk_frame(KA_SHORT_LEN, ADDR_MCAST, PROTO_KEEPALIVE, KA_REQUEST,
                         32'hFFFF_FFFF, tx_seq_m));
    send_header(mk_frame(KA_LONG_LEN, ADDR_UCAST, PROTO_KEEPALIVE, KA_REQUEST,
                         32'h1234_5678, 32'd0));
    send_header(mk_frame(KA_SHORT_LEN, ADDR_UCAST, PROTO_KEEPALIVE, 32'd3, 32'd0, 32'd0));
    send_header(mk_frame(KA_LONG_LEN, ADDR_MCAST, PROTO_KEEPALIVE, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
    configure(8'd10, 8'd25, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_header(mk_frame(KA_SHORT_LEN, ADDR_UCAST, PROTO_KEEPALIVE, KA_ADDR_REQUEST,
                         32'd0, 32'd0));
    // A short poll interval and timeout let a replied link age out within a few ticks.
    configure(8'd1, 8'd2, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_header(mk_frame(KA_LONG_LEN, ADDR_MCAST, PROTO_KEEPALIVE, KA_ADDR_REQUEST,
                         32'd0, 32'd0));
    send_header(mk_frame(KA_LONG_LEN, ADDR_MCAST, PROTO_KEEPALIVE, KA_REQUEST,
                         32'd77, tx_seq_m));
    repeat (4) send_header(mk_tick());
  endtask

  task automatic test_settings_sweep();
    configure(8'd0, 8'd2, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_random(200);
    configure(8'd1, 8'd255, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_random(200);
    configure(8'd255, 8'd2, $urandom, $urandom, 1'b1);
    send_random(200);
    configure(8'd3, 8'd7, $urandom, $urandom, 1'b1);
    send_random(200);
    configure(8'($urandom_range(1, 20)), 8'($urandom_range(2, 40)), $urandom, $urandom,
              1'($urandom_range(0, 1)));
    send_random(200);
  endtask

  task automatic test_output_stall();
    hold_off_seq = hold_off_seq + 1;
    send_random(20);
    drain_results();
  endtask

  task automatic test_steady_stream();
    configure(8'($urandom_range(1, 12)), 8'($urandom_range(2, 30)), $urandom, $urandom, 1'b1);
    quiet = 1'b1;
    send_random(300);
    drain_results();
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_seen != hold_off_seq) begin
      hold_off_seen <= hold_off_seq;
      sink_wait <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_wait <= $urandom_range(1, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[34:3],
             m_axis_tdata[66:35], m_axis_tdata[98:67], m_axis_tdata[99], m_axis_tdata[131:100]};
      if (expected_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= REPORT_MAX) $display("Unexpected result: %s", describe(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          failures = failures + 1;
          if (failures <= REPORT_MAX) begin
            $display("Mismatch, expected: %s", describe(want));
            $display("Mismatch, actual:   %s", describe(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hdlc_keepalive_link_monitor verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings_sweep();
    test_output_stall();
    test_steady_stream();
    if (failures == 0 && expected_results.size() == 0) begin
      $display("hdlc_keepalive_link_monitor verification clean");
    end else begin
      $display("hdlc_keepalive_link_monitor verification failed");
    end
    $finish;
  end

endmodule

// ===== hdlc_keepalive_link_monitor.f =====
hdl/hkm_pkg.sv
hdl/hkm_front.sv
hdl/hkm_queue.sv
hdl/hkm_back.sv
hdl/hdlc_keepalive_link_monitor.sv
test/tb_hdlc_keepalive_link_monitor.sv
